/* design/ptd_pkg.sv */
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and constants for the trial-division primality tester.
// ----------------------------------------------------------------------------
package ptd_pkg;

   // Default width of the number under test.
   localparam int NUM_WIDTH_DEFAULT = 32;

   // Wheel constants of the 6k +/- 1 search.
   localparam int FIRST_CAND = 5;
   localparam int WHEEL_STEP = 6;
   localparam int PAIR_GAP   = 2;
   localparam int SMALL_DIV  = 3;
   localparam int SMALL_MAX  = 3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_HOLD
   } state_type;

   // Which divisor the shared divider is working on.
   typedef enum logic [1:0] {
      DIV_THREE,
      DIV_LOW,
      DIV_HIGH
   } div_kind_type;

endpackage

/* design/primality_test_trial_division.sv */
// ----------------------------------------------------------------------------
// primality_test_trial_division
// Tests one unsigned number for primality by trial division over the
// 6k +/- 1 wheel, using one shared restoring divider under a small sequencer.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                               Direction   Payload
//   req       req_valid, req_ready, req_number    in          NUM_WIDTH-bit number
//   rsp       rsp_valid, rsp_ready, rsp_is_prime  out         1-bit prime flag
//
// The shared divider produces one quotient bit per cycle. Numbers 0..3 and
// even numbers are resolved without a division; an odd number first gets a
// division by three and then one division per wheel candidate, two per pair,
// until the square bound is passed or a divisor is found.
// The block takes no new transfer while a test is running.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// any pending result. A stalled result sits in the output register while the
// next number is accepted; a second finished result waits until it drains.
//
module primality_test_trial_division
   import ptd_pkg::*;
#(
   parameter int NUM_WIDTH = NUM_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [NUM_WIDTH-1:0] req_number,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_is_prime
);

   localparam int CNT_W = $clog2(NUM_WIDTH);

   localparam logic [NUM_WIDTH-1:0] CAND_FIRST = NUM_WIDTH'(FIRST_CAND);
   localparam logic [NUM_WIDTH-1:0] CAND_STEP  = NUM_WIDTH'(WHEEL_STEP);
   localparam logic [NUM_WIDTH-1:0] CAND_GAP   = NUM_WIDTH'(PAIR_GAP);
   localparam logic [NUM_WIDTH-1:0] DIV_BY3    = NUM_WIDTH'(SMALL_DIV);
   localparam logic [NUM_WIDTH-1:0] NUM_SMALL  = NUM_WIDTH'(SMALL_MAX);
   localparam logic [NUM_WIDTH-1:0] NUM_ONE    = NUM_WIDTH'(1);
   localparam logic [CNT_W-1:0]     CNT_LAST   = CNT_W'(NUM_WIDTH - 1);

   state_type             state_ff,  state_in;
   div_kind_type          kind_ff,   kind_in;
   logic [NUM_WIDTH-1:0]  num_ff,    num_in;
   logic [NUM_WIDTH-1:0]  cand_ff,   cand_in;
   logic [NUM_WIDTH-1:0]  div_ff,    div_in;
   logic [NUM_WIDTH-1:0]  rem_ff,    rem_in;
   logic [NUM_WIDTH-1:0]  quo_ff,    quo_in;
   logic [CNT_W-1:0]      cnt_ff,    cnt_in;
   logic                  res_ff,    res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_is_prime_ff, rsp_is_prime_in;

   // One restoring-division step: shift in the next dividend bit, then try
   // to subtract the divisor.
   logic [NUM_WIDTH:0]    div_shift;
   logic [NUM_WIDTH:0]    div_diff;
   logic                  div_ge;
   logic [NUM_WIDTH-1:0]  rem_step;
   logic [NUM_WIDTH-1:0]  quo_step;

   assign div_shift = {rem_ff, quo_ff[NUM_WIDTH-1]};
   assign div_diff  = div_shift - {1'b0, div_ff};
   assign div_ge    = ~div_diff[NUM_WIDTH];
   assign rem_step  = div_ge ? div_diff[NUM_WIDTH-1:0] : div_shift[NUM_WIDTH-1:0];
   assign quo_step  = {quo_ff[NUM_WIDTH-2:0], div_ge};

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff         <= kind_in;
      num_ff          <= num_in;
      cand_ff         <= cand_in;
      div_ff          <= div_in;
      rem_ff          <= rem_in;
      quo_ff          <= quo_in;
      cnt_ff          <= cnt_in;
      res_ff          <= res_in;
      rsp_is_prime_ff <= rsp_is_prime_in;
   end

   always_comb begin
      state_in        = state_ff;
      kind_in         = kind_ff;
      num_in          = num_ff;
      cand_in         = cand_ff;
      div_in          = div_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      cnt_in          = cnt_ff;
      res_in          = res_ff;
      rsp_is_prime_in = rsp_is_prime_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               num_in = req_number;
               if (req_number <= NUM_SMALL) begin
                  // Zero and one are not prime, two and three are.
                  res_in   = (req_number > NUM_ONE);
                  state_in = ST_HOLD;
               end else if (!req_number[0]) begin
                  res_in   = 1'b0;
                  state_in = ST_HOLD;
               end else begin
                  div_in   = DIV_BY3;
                  kind_in  = DIV_THREE;
                  rem_in   = '0;
                  quo_in   = req_number;
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end
            end
         end

         ST_DIV: begin
            rem_in = rem_step;
            quo_in = quo_step;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               // Division done; by default start the next one on the number.
               rem_in = '0;
               quo_in = num_ff;
               cnt_in = '0;
               case (kind_ff)
                  DIV_THREE: begin
                     if (rem_step == '0) begin
                        res_in   = 1'b0;
                        state_in = ST_HOLD;
                     end else begin
                        cand_in = CAND_FIRST;
                        div_in  = CAND_FIRST;
                        kind_in = DIV_LOW;
                     end
                  end
                  DIV_LOW: begin
                     // The quotient gives the square bound: stop once the
                     // candidate exceeds number / candidate.
                     if (cand_ff > quo_step) begin
                        res_in   = 1'b1;
                        state_in = ST_HOLD;
                     end else if (rem_step == '0) begin
                        res_in   = 1'b0;
                        state_in = ST_HOLD;
                     end else begin
                        div_in  = cand_ff + CAND_GAP;
                        kind_in = DIV_HIGH;
                     end
                  end
                  DIV_HIGH: begin
                     if (rem_step == '0) begin
                        res_in   = 1'b0;
                        state_in = ST_HOLD;
                     end else begin
                        cand_in = cand_ff + CAND_STEP;
                        div_in  = cand_ff + CAND_STEP;
                        kind_in = DIV_LOW;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_HOLD: begin
            // Load the output register once the previous transfer is gone.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_is_prime_in = res_ff;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Checks the trial-division primality tester against a behavioral primality
// predictor. Numbers are sent over the req channel and every prime flag on
// the rsp channel is compared with the prediction for the oldest number that
// is still waiting for its result. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
   import ptd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_W = NUM_WIDTH_DEFAULT;

   // Exactly 100 random numbers follow the directed ones.
   localparam int RANDOM_NUMBERS = 100;

   // After this many results the receiver holds off for a long stretch, so
   // that one result sits in the output register, a second one finishes
   // behind it, and the block stops taking new numbers.
   localparam int LONG_HOLD_AT     = 40;
   localparam int LONG_HOLD_CYCLES = 20000;

   // The slowest single number, the largest 32-bit prime, keeps both
   // channels quiet the longest. The limit leaves a wide margin.
   localparam int WATCHDOG_LIMIT = 3000000;

   // Cycles to keep watching the result channel after the last result.
   localparam int END_DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [NUM_W-1:0] number;
      logic             is_prime;
   } primality_entry_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [NUM_W-1:0] req_number = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_is_prime;

   // Numbers still to be offered, and for each one a mark that makes the
   // sender wait until every outstanding result has come back.
   logic [NUM_W-1:0]    numbers_to_send[$];
   bit                  drain_marks[$];
   // Numbers accepted by the block, with the flag the block should return.
   primality_entry_type primality_due[$];

   int unsigned numbers_queued   = 0;
   int unsigned numbers_sent     = 0;
   int unsigned numbers_accepted = 0;
   int unsigned results_seen     = 0;
   int unsigned mismatch_count   = 0;
   int unsigned send_wait;
   int unsigned recv_wait;
   int unsigned hold_left;
   int unsigned quiet_cycles     = 0;

   primality_test_trial_division #(
      .NUM_WIDTH(NUM_W)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_number  (req_number),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_is_prime(rsp_is_prime)
   );

   always #5 clock = ~clock;

   // Trial division over the 6k +/- 1 wheel. The bound d*d <= n is checked
   // as d <= n / d so that nothing can overflow.
   function automatic logic is_prime_by_trial(logic [NUM_W-1:0] value);
      longint unsigned n;
      longint unsigned d;
      n = value;
      if (n <= SMALL_MAX) return (n > 1);
      if ((n % 2) == 0 || (n % SMALL_DIV) == 0) return 1'b0;
      for (d = FIRST_CAND; d <= n / d; d += WHEEL_STEP) begin
         if ((n % d) == 0 || (n % (d + PAIR_GAP)) == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Idle cycles before the next transfer. Every other run of ten items has
   // no idling at all, so back-to-back traffic is covered as well.
   function automatic int unsigned idle_draw(int unsigned index);
      if (((index / 10) % 2) == 1) return 0;
      return $urandom_range(0, 16);
   endfunction

   // A random number, mostly small so that the run stays short. Large
   // numbers are built with a small factor, or made even, so that they
   // resolve quickly while still toggling every upper bit.
   function automatic logic [NUM_W-1:0] random_number();
      int unsigned     pick;
      int unsigned     factor;
      longint unsigned product;
      int unsigned     small_primes[12];
      small_primes = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
      pick = $urandom_range(0, 99);
      if (pick < 45) return $urandom_range(0, 4095);
      if (pick < 70) return $urandom_range(0, 65535);
      if (pick < 75) return $urandom_range(0, (1 << 20) - 1);
      if (pick < 90) begin
         factor  = small_primes[$urandom_range(0, 11)];
         product = longint'(factor) * $urandom_range(1, 32'hFFFF_FFFF / factor);
         return product[NUM_W-1:0];
      end
      return $urandom & ~32'd1;
   endfunction

   task automatic queue_number(logic [NUM_W-1:0] value, bit wait_for_drain);
      numbers_to_send.push_back(value);
      drain_marks.push_back(wait_for_drain);
      numbers_queued++;
   endtask

   // Sender: offers one number at a time. Once valid is raised it stays up
   // until the transfer, then a fresh idle count is drawn for the next one.
   always @(posedge clock) begin : req_side
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= idle_draw(0);
      end else begin
         if (req_valid && req_ready) begin
            primality_due.push_back('{number: req_number,
                                      is_prime: is_prime_by_trial(req_number)});
            numbers_accepted++;
         end
         // The slot is free unless a number is still waiting to be taken.
         if (!req_valid || req_ready) begin
            if (send_wait > 0) begin
               send_wait <= send_wait - 1;
               req_valid <= 1'b0;
            end else if (numbers_to_send.size() == 0 ||
                         (drain_marks[0] && primality_due.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               req_number <= numbers_to_send.pop_front();
               void'(drain_marks.pop_front());
               req_valid  <= 1'b1;
               send_wait  <= idle_draw(numbers_sent);
               numbers_sent++;
            end
         end
      end
   end

   // Receiver: checks every result transfer against the oldest prediction.
   // Its idle count runs down only while a result is being offered, so the
   // stalls land on real results and not on the long compute gaps.
   always @(posedge clock) begin : rsp_side
      int unsigned         wait_draw;
      primality_entry_type due;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait <= 0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= (hold_left == 1);
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (primality_due.size() == 0) begin
               $error("rsp transfer with no prediction waiting: is_prime %0b",
                      rsp_is_prime);
               mismatch_count++;
            end else begin
               due = primality_due.pop_front();
               if (rsp_is_prime !== due.is_prime) begin
                  $error("is_prime for number %0d: expected %0b, actual %0b",
                         due.number, due.is_prime, rsp_is_prime);
                  mismatch_count++;
               end
            end
            results_seen++;
            if (results_seen == LONG_HOLD_AT) begin
               hold_left <= LONG_HOLD_CYCLES;
               rsp_ready <= 1'b0;
            end else begin
               wait_draw = idle_draw(results_seen);
               recv_wait <= wait_draw;
               rsp_ready <= (wait_draw == 0);
            end
         end else if (rsp_valid && recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            rsp_ready <= (recv_wait == 1);
         end else if (recv_wait == 0) begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run when neither channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // Directed numbers: the small cases, squares of wheel candidates,
      // divisors hit by either member of a pair, and the field extremes.
      queue_number(0, 1'b0);
      queue_number(1, 1'b0);
      queue_number(2, 1'b0);
      queue_number(3, 1'b0);
      queue_number(4, 1'b0);
      queue_number(5, 1'b0);
      queue_number(6, 1'b0);
      queue_number(7, 1'b0);
      queue_number(9, 1'b0);
      queue_number(25, 1'b0);           // equal to the square of the first candidate
      queue_number(35, 1'b0);           // found by the lower member of the first pair
      queue_number(49, 1'b0);
      queue_number(121, 1'b0);
      queue_number(143, 1'b0);
      queue_number(169, 1'b0);
      queue_number(323, 1'b0);
      queue_number(97, 1'b0);
      queue_number(65521, 1'b0);        // largest 16-bit prime
      queue_number(65535, 1'b0);
      queue_number(32'h8000_0000, 1'b0);
      queue_number(32'hAAAA_AAAA, 1'b0);
      queue_number(32'h5555_5555, 1'b0);
      queue_number(32'hFFFF_FFFF, 1'b0);
      queue_number(16777213, 1'b0);
      // Largest 32-bit prime: the search runs right up to the square bound.
      queue_number(32'hFFFF_FFFB, 1'b0);

      // The first random number waits until the directed results are all in.
      for (int i = 0; i < RANDOM_NUMBERS; i++) begin
         queue_number(random_number(), (i == 0));
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (numbers_accepted < numbers_queued) @(posedge clock);
      while (primality_due.size() != 0) @(posedge clock);
      repeat (END_DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
